>>> rtl/elevator_look_dispatcher_top_defines.svh
// Assertion macros used by the dispatcher RTL.
`ifndef ELEVATOR_LOOK_DISPATCHER_TOP_DEFINES_SVH
`define ELEVATOR_LOOK_DISPATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ELD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ELD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELD_ASSERT_RST(label, prop, msg)
`define ELD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/eld_pkg.sv
package eld_pkg;

  localparam int MAP_BITS    = 32;
  localparam int FLOOR_W     = 5;
  localparam int CAR_FIELD_W = 3;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] CARS_IN_USE_RESET = 4'd2;
  localparam logic             REG_CARS_IN_USE   = 1'b0;

  typedef enum logic [1:0] {
    HEAD_UP   = 2'd0,
    HEAD_DOWN = 2'd1,
    HEAD_NONE = 2'd2
  } heading_t;

  typedef enum logic [1:0] {
    FUNC_HALL = 2'd0,
    FUNC_CAR  = 2'd1,
    FUNC_STEP = 2'd2
  } func_t;

  typedef enum logic {
    KIND_HALL   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HSCAN,
    ST_HPICK,
    ST_HWR,
    ST_CWR,
    ST_STEP
  } state_t;

  typedef struct packed {
    logic [MAP_BITS-1:0] request_map;
    logic [FLOOR_W-1:0]  car_floor;
    logic                car_moving;
    heading_t            car_heading;
  } car_state_t;

  localparam car_state_t CAR_RESET = '{
    request_map: '0,
    car_floor:   '0,
    car_moving:  1'b0,
    car_heading: HEAD_NONE
  };

  typedef struct packed {
    func_t                  func;
    logic [FLOOR_W-1:0]     floor;
    logic                   hall_direction;
    logic [CAR_FIELD_W-1:0] car_select;
  } req_t;

  typedef struct packed {
    kind_t                  kind;
    logic [CAR_FIELD_W-1:0] car_index;
    logic [FLOOR_W-1:0]     car_floor_out;
    logic                   moving;
    heading_t               heading;
    logic                   last;
  } rsp_t;

endpackage

>>> rtl/eld_state_mem.sv
module eld_state_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output eld_pkg::car_state_t rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  eld_pkg::car_state_t wr_data
);

  eld_pkg::car_state_t mem [DEPTH];
  logic [DEPTH-1:0]    valid;
  eld_pkg::car_state_t rd_q;
  logic                rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as the reset car state.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_q : eld_pkg::CAR_RESET;

endmodule

>>> rtl/eld_look.sv
module eld_look (
  input  eld_pkg::car_state_t cur,
  output eld_pkg::car_state_t nxt
);

  logic [eld_pkg::MAP_BITS-1:0] up_set;
  logic [eld_pkg::MAP_BITS-1:0] down_set;
  logic [eld_pkg::FLOOR_W-1:0]  up_lo;
  logic [eld_pkg::FLOOR_W-1:0]  down_hi;
  eld_pkg::heading_t            head;
  logic                         go_up;

  // Requests at or above the car, and at or below it.
  assign up_set   = cur.request_map & ({eld_pkg::MAP_BITS{1'b1}} << cur.car_floor);
  assign down_set = cur.request_map &
                    ~({eld_pkg::MAP_BITS{1'b1}} << ({1'b0, cur.car_floor} + 6'd1));

  always_comb begin
    up_lo = '0;
    for (int i = eld_pkg::MAP_BITS - 1; i >= 0; i--) begin
      if (up_set[i]) begin
        up_lo = eld_pkg::FLOOR_W'(i);
      end
    end
  end

  always_comb begin
    down_hi = '0;
    for (int i = 0; i < eld_pkg::MAP_BITS; i++) begin
      if (down_set[i]) begin
        down_hi = eld_pkg::FLOOR_W'(i);
      end
    end
  end

  always_comb begin
    nxt = cur;
    // A car without a heading starts up only when nothing waits at or below it.
    if (cur.car_heading == eld_pkg::HEAD_UP || cur.car_heading == eld_pkg::HEAD_DOWN) begin
      head = cur.car_heading;
    end else begin
      head = (down_set == '0) ? eld_pkg::HEAD_UP : eld_pkg::HEAD_DOWN;
    end
    // With any request pending, one of the two sides is never empty.
    if (head == eld_pkg::HEAD_UP) begin
      go_up = (up_set != '0);
    end else begin
      go_up = (down_set == '0);
    end
    if (cur.request_map == '0) begin
      nxt.car_moving  = 1'b0;
      nxt.car_heading = eld_pkg::HEAD_NONE;
    end else if (go_up) begin
      nxt.car_moving             = 1'b1;
      nxt.car_heading            = eld_pkg::HEAD_UP;
      nxt.car_floor              = up_lo;
      nxt.request_map[up_lo]     = 1'b0;
    end else begin
      nxt.car_moving             = 1'b1;
      nxt.car_heading            = eld_pkg::HEAD_DOWN;
      nxt.car_floor              = down_hi;
      nxt.request_map[down_hi]   = 1'b0;
    end
  end

endmodule

>>> rtl/elevator_look_dispatcher_top.sv
// Car state sits in one memory, one entry per car, one read and one write a cycle.
// Hall call: the active cars are read and scanned in turn, one is picked, and it is
// read, modified and written back, issuing the result once the output has room.
// Car call: read, write back, no result. Step: one car read, moved and reported per
// cycle while the output has room, n results. The next item is taken once the last
// is done. Synchronous reset clears the car memory to idle cars, cars_in_use to 2.
`include "elevator_look_dispatcher_top_defines.svh"

module elevator_look_dispatcher_top #(
  parameter int NUM_CARS   = 8,
  parameter int NUM_FLOORS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  eld_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output eld_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int CW        = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int NMAX      = (NUM_CARS < 8) ? NUM_CARS : 8;
  localparam int FLOOR_TOP = (NUM_FLOORS < 32) ? NUM_FLOORS - 1 : 31;

  localparam logic [eld_pkg::CFG_W-1:0]   N_LIMIT  = eld_pkg::CFG_W'(NMAX);
  localparam logic [eld_pkg::FLOOR_W-1:0] FL_LIMIT = eld_pkg::FLOOR_W'(FLOOR_TOP);

  eld_pkg::state_t              state, state_next;
  logic [eld_pkg::CFG_W-1:0]    cars_in_use;
  logic [eld_pkg::CFG_W-1:0]    n_cfg;
  logic [eld_pkg::CFG_W-1:0]    n, n_next;
  logic [eld_pkg::FLOOR_W-1:0]  fl, fl_next;
  logic [eld_pkg::FLOOR_W-1:0]  req_fl;
  logic                         dir, dir_next;
  logic [2:0]                   sel, sel_next;
  logic [2:0]                   k, k_next;
  logic [2:0]                   pick, pick_next;
  logic [2:0]                   fp, fp_next;
  logic [2:0]                   fb;
  logic                         r1_found, r1_found_next;
  logic [2:0]                   r1_car, r1_car_next;
  logic                         id_found, id_found_next;
  logic [2:0]                   id_car, id_car_next;
  logic [eld_pkg::FLOOR_W-1:0]  id_dist, id_dist_next;
  logic                         r3_found, r3_found_next;
  logic [2:0]                   r3_car, r3_car_next;

  logic                         rd_en, wr_en;
  logic [CW-1:0]                rd_addr, wr_addr;
  eld_pkg::car_state_t          rd_data, wr_data, looked;
  logic                         emit, out_free, k_last;
  eld_pkg::rsp_t                emit_item;
  logic [eld_pkg::FLOOR_W-1:0]  call_gap;
  logic                         above, below, hit1, hit_idle, hit3;
  logic [eld_pkg::MAP_BITS-1:0] fl_bit;
  eld_pkg::heading_t            want_head;

  eld_state_mem #(
    .DEPTH (NUM_CARS),
    .AW    (CW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  eld_look u_look (
    .cur (rd_data),
    .nxt (looked)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == eld_pkg::REG_CARS_IN_USE) ? {28'd0, cars_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cars_in_use <= eld_pkg::CARS_IN_USE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == eld_pkg::REG_CARS_IN_USE) begin
      cars_in_use <= pwdata[eld_pkg::CFG_W-1:0];
    end
  end

  assign n_cfg  = (cars_in_use == '0) ? 4'd1 :
                  (cars_in_use > N_LIMIT) ? N_LIMIT : cars_in_use;
  assign req_fl = (req.floor > FL_LIMIT) ? FL_LIMIT : req.floor;

  // Per-car terms for the hall call scan, on the car read last cycle.
  assign above     = rd_data.car_floor > fl;
  assign below     = rd_data.car_floor < fl;
  assign call_gap  = above ? rd_data.car_floor - fl : fl - rd_data.car_floor;
  assign want_head = dir ? eld_pkg::HEAD_DOWN : eld_pkg::HEAD_UP;
  assign hit3      = dir ? above : below;
  assign hit1      = rd_data.car_moving && rd_data.car_heading == want_head && hit3;
  assign hit_idle  = !rd_data.car_moving && (!id_found || call_gap < id_dist);

  assign fl_bit   = eld_pkg::MAP_BITS'(1) << fl;
  assign out_free = !rsp_valid || rsp_ready;
  assign k_last   = ({1'b0, k} + 4'd1) == n;
  assign fb       = ({1'b0, fp} < n) ? fp : 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eld_pkg::ST_IDLE;
      fp    <= '0;
    end else begin
      state <= state_next;
      fp    <= fp_next;
    end
  end

  always_ff @(posedge clk) begin
    n        <= n_next;
    fl       <= fl_next;
    dir      <= dir_next;
    sel      <= sel_next;
    k        <= k_next;
    pick     <= pick_next;
    r1_found <= r1_found_next;
    r1_car   <= r1_car_next;
    id_found <= id_found_next;
    id_car   <= id_car_next;
    id_dist  <= id_dist_next;
    r3_found <= r3_found_next;
    r3_car   <= r3_car_next;
  end

  always_comb begin
    state_next    = state;
    n_next        = n;
    fl_next       = fl;
    dir_next      = dir;
    sel_next      = sel;
    k_next        = k;
    pick_next     = pick;
    fp_next       = fp;
    r1_found_next = r1_found;
    r1_car_next   = r1_car;
    id_found_next = id_found;
    id_car_next   = id_car;
    id_dist_next  = id_dist;
    r3_found_next = r3_found;
    r3_car_next   = r3_car;
    req_ready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = CW'(pick);
    wr_data       = rd_data;
    emit          = 1'b0;
    emit_item     = '{
      kind:          eld_pkg::KIND_HALL,
      car_index:     pick,
      car_floor_out: rd_data.car_floor,
      moving:        rd_data.car_moving,
      heading:       rd_data.car_heading,
      last:          1'b1
    };

    case (state)
      eld_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          n_next        = n_cfg;
          fl_next       = req_fl;
          dir_next      = req.hall_direction;
          sel_next      = req.car_select;
          k_next        = '0;
          r1_found_next = 1'b0;
          id_found_next = 1'b0;
          r3_found_next = 1'b0;
          case (req.func)
            eld_pkg::FUNC_HALL: begin
              rd_en      = 1'b1;
              state_next = eld_pkg::ST_HSCAN;
            end
            eld_pkg::FUNC_CAR: begin
              // A car call to a car outside the active set is dropped.
              if ({1'b0, req.car_select} < n_cfg) begin
                rd_en      = 1'b1;
                rd_addr    = CW'(req.car_select);
                state_next = eld_pkg::ST_CWR;
              end
            end
            eld_pkg::FUNC_STEP: begin
              rd_en      = 1'b1;
              state_next = eld_pkg::ST_STEP;
            end
            default: begin
              state_next = eld_pkg::ST_IDLE;
            end
          endcase
        end
      end

      eld_pkg::ST_HSCAN: begin
        if (hit1 && !r1_found) begin
          r1_found_next = 1'b1;
          r1_car_next   = k;
        end
        if (hit_idle) begin
          id_found_next = 1'b1;
          id_car_next   = k;
          id_dist_next  = call_gap;
        end
        if (hit3 && !r3_found) begin
          r3_found_next = 1'b1;
          r3_car_next   = k;
        end
        if (k_last) begin
          state_next = eld_pkg::ST_HPICK;
        end else begin
          k_next  = k + 3'd1;
          rd_en   = 1'b1;
          rd_addr = CW'(k + 3'd1);
        end
      end

      eld_pkg::ST_HPICK: begin
        if (r1_found) begin
          pick_next = r1_car;
        end else if (id_found) begin
          pick_next = id_car;
        end else if (r3_found) begin
          pick_next = r3_car;
        end else begin
          // Last resort: the wrapping fallback pointer, which moves only here.
          pick_next = fb;
          fp_next   = (({1'b0, fb} + 4'd1) < n) ? fb + 3'd1 : 3'd0;
        end
        rd_en      = 1'b1;
        rd_addr    = CW'(pick_next);
        state_next = eld_pkg::ST_HWR;
      end

      eld_pkg::ST_HWR: begin
        if (out_free) begin
          wr_en               = 1'b1;
          wr_data.request_map = rd_data.request_map | fl_bit;
          emit                = 1'b1;
          state_next          = eld_pkg::ST_IDLE;
        end
      end

      eld_pkg::ST_CWR: begin
        wr_en               = 1'b1;
        wr_addr             = CW'(sel);
        wr_data.request_map = rd_data.request_map | fl_bit;
        state_next          = eld_pkg::ST_IDLE;
      end

      eld_pkg::ST_STEP: begin
        emit_item = '{
          kind:          eld_pkg::KIND_STATUS,
          car_index:     k,
          car_floor_out: looked.car_floor,
          moving:        looked.car_moving,
          heading:       looked.car_heading,
          last:          k_last
        };
        if (out_free) begin
          wr_en   = 1'b1;
          wr_addr = CW'(k);
          wr_data = looked;
          emit    = 1'b1;
          if (k_last) begin
            state_next = eld_pkg::ST_IDLE;
          end else begin
            k_next  = k + 3'd1;
            rd_en   = 1'b1;
            rd_addr = CW'(k + 3'd1);
          end
        end
      end

      default: begin
        state_next = eld_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_item;
    end
  end

  // The memory has no bypass, so a read never targets the entry written that cycle.
  `ELD_ASSERT_RST(a_no_rw_same_entry, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit the same car entry")
  `ELD_ASSERT_RST(a_pick_active, (state == eld_pkg::ST_HWR) |-> ({1'b0, pick} < n), "hall call assigned to an inactive car")
  `ELD_ASSERT_RST(a_step_active, (state == eld_pkg::ST_STEP) |-> ({1'b0, k} < n), "step visits an inactive car")
  `ELD_ASSERT_ALWAYS(a_emit_has_room, emit |-> out_free, "result issued while the output register is full")

endmodule
